// ===== design/debris_flow_outflow_minimization_defines.svh =====
// Assertion macros shared by the outflow minimization RTL.
`ifndef DEBRIS_FLOW_OUTFLOW_MINIMIZATION_DEFINES_SVH
`define DEBRIS_FLOW_OUTFLOW_MINIMIZATION_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DFOM_ASSERT_IMPL(lbl, pre, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define DFOM_ASSERT_NEXT(lbl, pre, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (con)) \
        else $error("assertion failed");

`endif

// ===== design/dfom_pkg.sv =====
// ----------------------------------------------------------------------------
// dfom_pkg
// Types and constants of the debris-flow outflow minimization block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package dfom_pkg;

    localparam int DATA_W   = 32;   // Q16.16 fields
    localparam int VAL_W    = 33;   // field plus epsilon
    localparam int SUM_W    = 36;   // base plus up to five values
    localparam int CNT_W    = 3;    // survivor count 0..5
    localparam int DIFF_W   = 36;   // nonnegative difference
    localparam int LO_W     = 20;   // low slice of the difference
    localparam int HI_W     = DIFF_W - LO_W;
    localparam int RATE_W   = 17;
    localparam int EPS_W    = 16;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = DIFF_W + RATE_W;
    localparam int DVD_W    = PROD_W - FRAC_W;
    localparam int STEP_W   = 6;
    localparam int PASS_W   = 3;
    localparam int MAX_PASSES = 6;
    localparam int IDX_W    = 2;

    localparam logic [RATE_W-1:0] RATE_RESET = 17'd32768;
    localparam logic [EPS_W-1:0]  EPS_RESET  = 16'd66;

    localparam logic [IDX_W-1:0] REG_RATE = 2'd0;
    localparam logic [IDX_W-1:0] REG_EPS  = 2'd1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_CMP,
        ST_MUL,
        ST_ADD,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic load;
        logic cmp;
        logic mul;
        logic add;
        logic div;
    } lane_ctl_t;

endpackage
`default_nettype wire

// ===== design/dfom_lane.sv =====
// ----------------------------------------------------------------------------
// dfom_lane
// One neighbor: elimination test, outflow product and bit-serial divide.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "debris_flow_outflow_minimization_defines.svh"
module dfom_lane
    import dfom_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire lane_ctl_t                ctl,
    input  wire logic signed [DATA_W-1:0] total,
    input  wire logic signed [SUM_W-1:0]  sum,
    input  wire logic [CNT_W-1:0]         cnt,
    input  wire logic [RATE_W-1:0]        rate,
    output logic signed [VAL_W-1:0]       val,
    output logic                          gone,
    output logic                          newly,
    output logic signed [DATA_W-1:0]      outflow
);

    logic signed [VAL_W-1:0]    val_reg;
    logic                       gone_reg;
    logic [LO_W+RATE_W-1:0]     pl_reg;
    logic [HI_W+RATE_W-1:0]     ph_reg;
    logic [DVD_W-1:0]           q_reg;
    logic [CNT_W-1:0]           rem_reg;

    logic signed [SUM_W:0]      scaled;
    logic signed [SUM_W:0]      diff_s;
    logic [DIFF_W-1:0]          diff;
    logic [PROD_W-1:0]          prod;
    logic [CNT_W:0]             trial;

    always_comb
    begin
        scaled = SUM_W'(val_reg) * $signed({1'b0, cnt});
        diff_s = (SUM_W+1)'(sum) - scaled;
        if (gone_reg || diff_s < 0)
            diff = '0;
        else
            diff = diff_s[DIFF_W-1:0];
        newly = !gone_reg && ((SUM_W+1)'(sum) <= scaled);
        prod  = ({(PROD_W-HI_W-RATE_W)'(0), ph_reg} << LO_W)
              + PROD_W'(pl_reg);
        trial = {rem_reg, q_reg[DVD_W-1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gone_reg <= 1'b0;
        end
        else if (ctl.load)
        begin
            gone_reg <= 1'b0;
        end
        else if (ctl.cmp && newly)
        begin
            gone_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            val_reg <= VAL_W'(total);
        if (ctl.mul)
        begin
            pl_reg <= diff[LO_W-1:0] * rate;
            ph_reg <= diff[DIFF_W-1:LO_W] * rate;
        end
        if (ctl.add)
        begin
            q_reg   <= prod[PROD_W-1:FRAC_W];
            rem_reg <= '0;
        end
        else if (ctl.div)
        begin
            // restoring divide by the survivor count, one quotient bit a step
            if (trial >= {1'b0, cnt})
            begin
                rem_reg <= CNT_W'(trial - {1'b0, cnt});
                q_reg   <= {q_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[CNT_W-1:0];
                q_reg   <= {q_reg[DVD_W-2:0], 1'b0};
            end
        end
    end

    assign val  = val_reg;
    assign gone = gone_reg;

    always_comb
    begin
        if (gone_reg)
            outflow = '0;
        else if (q_reg > DVD_W'(32'h7FFF_FFFF))
            outflow = 32'sh7FFF_FFFF;
        else
            outflow = q_reg[DATA_W-1:0];
    end

    `DFOM_ASSERT_NEXT(a_gone_sticky, gone_reg && !ctl.load, gone_reg)

endmodule
`default_nettype wire

// ===== design/debris_flow_outflow_minimization.sv =====
// ----------------------------------------------------------------------------
// debris_flow_outflow_minimization
// Minimization-of-differences outflow for one cell and its four neighbors.
// ----------------------------------------------------------------------------
// One item at a time. Each elimination pass (1..6 passes) sums the
// survivors in the sum state and runs the four lane compares in the compare
// state; then a split multiply forms two partial products, the add state sums
// them, and a bit-serial divide by the survivor count in each lane yields one
// quotient bit per step. A finished result sits in the output register
// while the next item is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "debris_flow_outflow_minimization_defines.svh"
module debris_flow_outflow_minimization
    import dfom_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_valid,
    output logic                          cfg_ready,
    input  wire logic [IDX_W-1:0]         cfg_index,
    input  wire logic [RATE_W-1:0]        cfg_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic signed [DATA_W-1:0] cell_altitude,
    input  wire logic signed [DATA_W-1:0] cell_depth,
    input  wire logic signed [DATA_W-1:0] north_total,
    input  wire logic signed [DATA_W-1:0] west_total,
    input  wire logic signed [DATA_W-1:0] east_total,
    input  wire logic signed [DATA_W-1:0] south_total,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic signed [DATA_W-1:0]      north_outflow,
    output logic signed [DATA_W-1:0]      west_outflow,
    output logic signed [DATA_W-1:0]      east_outflow,
    output logic signed [DATA_W-1:0]      south_outflow
);

    state_t                  state_reg, state_next;
    logic [RATE_W-1:0]       rate_reg;
    logic [EPS_W-1:0]        eps_reg;
    logic [PASS_W-1:0]       pass_reg;
    logic [STEP_W-1:0]       step_reg;
    logic signed [VAL_W-1:0] cval_reg;
    logic signed [VAL_W-1:0] base_reg;
    logic                    cgone_reg;
    logic signed [SUM_W-1:0] sum_reg, sum_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    out_valid_reg;
    logic signed [DATA_W-1:0] out_reg [4];

    lane_ctl_t               ctl;
    logic                    accept;
    logic                    fin_load;
    logic                    cnewly;
    logic                    changed;
    logic signed [SUM_W:0]   cscaled;
    logic signed [DATA_W-1:0] totals [4];
    logic signed [VAL_W-1:0] lval [4];
    logic [3:0]              lgone;
    logic [3:0]              lnewly;
    logic signed [DATA_W-1:0] lout [4];

    assign totals[0] = north_total;
    assign totals[1] = west_total;
    assign totals[2] = east_total;
    assign totals[3] = south_total;

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_lane
            dfom_lane u_lane (
                .clk     (clk),
                .rst_n   (rst_n),
                .ctl     (ctl),
                .total   (totals[g]),
                .sum     (sum_reg),
                .cnt     (cnt_reg),
                .rate    (rate_reg),
                .val     (lval[g]),
                .gone    (lgone[g]),
                .newly   (lnewly[g]),
                .outflow (lout[g])
            );
        end
    endgenerate

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign fin_load  = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    // merge: survivor sum and count, centre compare
    always_comb
    begin
        sum_next = SUM_W'(base_reg);
        cnt_next = '0;
        if (!cgone_reg)
        begin
            sum_next = sum_next + SUM_W'(cval_reg);
            cnt_next = cnt_next + 1'b1;
        end
        for (int i = 0; i < 4; i++)
        begin
            if (!lgone[i])
            begin
                sum_next = sum_next + SUM_W'(lval[i]);
                cnt_next = cnt_next + 1'b1;
            end
        end
        cscaled = SUM_W'(cval_reg) * $signed({1'b0, cnt_reg});
        cnewly  = !cgone_reg && ((SUM_W+1)'(sum_reg) <= cscaled);
        changed = cnewly || (|lnewly);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_SUM;
            ST_SUM:  state_next = ST_CMP;
            ST_CMP:
            begin
                if (!changed || pass_reg == PASS_W'(MAX_PASSES - 1))
                    state_next = ST_MUL;
                else
                    state_next = ST_SUM;
            end
            ST_MUL:  state_next = ST_ADD;
            ST_ADD:  state_next = ST_DIV;
            ST_DIV:  if (step_reg == STEP_W'(DVD_W - 1)) state_next = ST_FIN;
            ST_FIN:  if (fin_load) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ctl.load = accept;
        ctl.cmp  = (state_reg == ST_CMP);
        ctl.mul  = (state_reg == ST_MUL);
        ctl.add  = (state_reg == ST_ADD);
        ctl.div  = (state_reg == ST_DIV);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rate_reg      <= RATE_RESET;
            eps_reg       <= EPS_RESET;
            pass_reg      <= '0;
            step_reg      <= '0;
            cgone_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_RATE: rate_reg <= cfg_data;
                    REG_EPS:  eps_reg  <= cfg_data[EPS_W-1:0];
                    default:  ;
                endcase
            end
            if (accept)
            begin
                pass_reg  <= '0;
                cgone_reg <= 1'b0;
            end
            else if (ctl.cmp)
            begin
                pass_reg <= pass_reg + 1'b1;
                if (cnewly)
                    cgone_reg <= 1'b1;
            end
            if (ctl.add)
                step_reg <= '0;
            else if (ctl.div)
                step_reg <= step_reg + 1'b1;
            if (fin_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cval_reg <= VAL_W'(cell_altitude) + VAL_W'(eps_reg);
            base_reg <= VAL_W'(cell_depth) - VAL_W'(eps_reg);
        end
        if (state_reg == ST_SUM)
        begin
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
        end
        if (fin_load)
        begin
            for (int i = 0; i < 4; i++)
                out_reg[i] <= lout[i];
        end
    end

    assign out_valid     = out_valid_reg;
    assign north_outflow = out_reg[0];
    assign west_outflow  = out_reg[1];
    assign east_outflow  = out_reg[2];
    assign south_outflow = out_reg[3];

    `DFOM_ASSERT_NEXT(a_out_holds, out_valid_reg && !out_ready, out_valid_reg)
    `DFOM_ASSERT_IMPL(a_pass_bound, state_reg == ST_CMP,
        pass_reg < PASS_W'(MAX_PASSES))
    `DFOM_ASSERT_IMPL(a_div_bound, state_reg == ST_DIV, step_reg < STEP_W'(DVD_W))

endmodule
`default_nettype wire

// ===== tb/sv/outflow_checker.sv =====
// ----------------------------------------------------------------------------
// outflow_checker
// Watches the config, input and output channels of the outflow minimization
// block, predicts each result from the accepted items and compares fields.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module outflow_checker
    import dfom_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    input  logic                     cfg_ready,
    input  logic [IDX_W-1:0]         cfg_index,
    input  logic [RATE_W-1:0]        cfg_data,
    input  logic                     in_valid,
    input  logic                     in_ready,
    input  logic signed [DATA_W-1:0] cell_altitude,
    input  logic signed [DATA_W-1:0] cell_depth,
    input  logic signed [DATA_W-1:0] north_total,
    input  logic signed [DATA_W-1:0] west_total,
    input  logic signed [DATA_W-1:0] east_total,
    input  logic signed [DATA_W-1:0] south_total,
    input  logic                     out_valid,
    input  logic                     out_ready,
    input  logic signed [DATA_W-1:0] north_outflow,
    input  logic signed [DATA_W-1:0] west_outflow,
    input  logic signed [DATA_W-1:0] east_outflow,
    input  logic signed [DATA_W-1:0] south_outflow,
    output int                       errors,
    output int                       pending
);

    typedef logic [4*DATA_W-1:0] flows_t;

    logic [RATE_W-1:0] rate_q;
    logic [EPS_W-1:0]  eps_q;
    flows_t            flows_due[$];

    function automatic flows_t outflows(input logic signed [DATA_W-1:0] alt,
                                        input logic signed [DATA_W-1:0] dep,
                                        input logic signed [DATA_W-1:0] n,
                                        input logic signed [DATA_W-1:0] w,
                                        input logic signed [DATA_W-1:0] e,
                                        input logic signed [DATA_W-1:0] s,
                                        input logic [RATE_W-1:0] rate,
                                        input logic [EPS_W-1:0] eps);
        longint h[5];
        bit     gone[5];
        longint base, acc, cnt, diff, q;
        bit     changed;
        flows_t r;
        base = longint'(dep) - longint'(eps);
        h[0] = longint'(alt) + longint'(eps);
        h[1] = n; h[2] = w; h[3] = e; h[4] = s;
        gone = '{default: 0};
        acc = base;
        cnt = 0;
        for (int p = 0; p < MAX_PASSES; p++)
        begin
            changed = 0;
            acc = base;
            cnt = 0;
            for (int k = 0; k < 5; k++)
                if (!gone[k])
                begin
                    acc += h[k];
                    cnt++;
                end
            if (cnt == 0)
                break;
            for (int k = 0; k < 5; k++)
                if (!gone[k] && acc <= h[k] * cnt)
                begin
                    gone[k] = 1;
                    changed = 1;
                end
            if (!changed)
                break;
        end
        r = '0;
        for (int k = 1; k < 5; k++)
        begin
            q = 0;
            if (!gone[k] && cnt > 0)
            begin
                diff = acc - h[k] * cnt;
                if (diff < 0)
                    diff = 0;
                q = (diff * longint'(rate)) / (cnt * 65536);
                if (q > 64'sh7FFFFFFF)
                    q = 64'sh7FFFFFFF;
            end
            r[(4-k)*DATA_W +: DATA_W] = q[DATA_W-1:0];
        end
        return r;
    endfunction

    assign pending = flows_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        flows_t got, want;
        if (!rst_n)
        begin
            rate_q <= RATE_RESET;
            eps_q  <= EPS_RESET;
            errors <= 0;
            flows_due.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_RATE)
                    rate_q <= cfg_data;
                else if (cfg_index == REG_EPS)
                    eps_q <= cfg_data[EPS_W-1:0];
            end
            if (in_valid && in_ready)
                flows_due.push_back(outflows(cell_altitude, cell_depth, north_total,
                                             west_total, east_total, south_total,
                                             rate_q, eps_q));
            if (out_valid && out_ready)
            begin
                got = {north_outflow, west_outflow, east_outflow, south_outflow};
                if (flows_due.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected item: %h", got);
                    errors <= errors + 1;
                end
                else
                begin
                    want = flows_due.pop_front();
                    if (got !== want)
                    begin
                        if (errors < 10)
                            $display("mismatch n/w/e/s expected %h got %h", want, got);
                        errors <= errors + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Stimulus for the outflow minimization block: directed corner cells, then
// random cells near and far across several register settings, random gaps.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
    import dfom_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic clk, rst_n;
    logic cfg_valid, cfg_ready;
    logic [IDX_W-1:0] cfg_index;
    logic [RATE_W-1:0] cfg_data;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [DATA_W-1:0] cell_altitude, cell_depth;
    logic signed [DATA_W-1:0] north_total, west_total, east_total, south_total;
    logic signed [DATA_W-1:0] north_outflow, west_outflow, east_outflow, south_outflow;
    int errors, pending;
    int quiet = 0;

    debris_flow_outflow_minimization DUT (.*);

    outflow_checker chk (.*);

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    // receiver gaps; ready stays up when no gap is drawn
    initial
    begin
        int w;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (w > 0)
            begin
                out_ready <= 0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1;
            do @(posedge clk); while (!out_valid);
        end
    end

    // watchdog on cycles with no handshake on the config, input or output channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [RATE_W-1:0] v);
        cfg_index <= idx;
        cfg_data  <= v;
        cfg_valid <= 1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 0;
        @(posedge clk);
    endtask

    // valid is only lowered when a gap is drawn, so back to back items keep it up
    task automatic send_cell(input logic signed [DATA_W-1:0] a, d, n, w, e, s);
        int g;
        g = $urandom_range(0, 7) < 3 ? 0 : $urandom_range(0, 4);
        if (g > 0)
        begin
            in_valid <= 0;
            repeat (g) @(posedge clk);
        end
        cell_altitude <= a;
        cell_depth    <= d;
        north_total   <= n;
        west_total    <= w;
        east_total    <= e;
        south_total   <= s;
        in_valid      <= 1;
        do @(posedge clk); while (!in_ready);
    endtask

    // wait until all results are back, plus the block's latency
    task automatic drain();
        in_valid <= 0;
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    function automatic logic signed [DATA_W-1:0] any32();
        return $urandom();
    endfunction

    // a height near the given centre so neighbors straddle it
    function automatic logic signed [DATA_W-1:0] near(input logic signed [DATA_W-1:0] c);
        return c + $signed($urandom_range(0, 20 * 65536)) - 10 * 65536;
    endfunction

    task automatic random_cell();
        logic signed [DATA_W-1:0] c;
        if ($urandom_range(0, 9) < 2)
            send_cell(any32(), any32(), any32(), any32(), any32(), any32());
        else
        begin
            c = $signed($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
            send_cell(c, $signed($urandom_range(0, 8 * 65536)),
                      near(c), near(c), near(c), near(c));
        end
    endtask

    localparam logic signed [DATA_W-1:0] MX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] MN = 32'sh8000_0000;

    initial
    begin
        logic [RATE_W-1:0] rates[4];
        logic [EPS_W-1:0]  epss[4];
        rst_n = 0;
        cfg_valid = 0; cfg_index = '0; cfg_data = '0;
        in_valid = 0;
        cell_altitude = 0; cell_depth = 0;
        north_total = 0; west_total = 0; east_total = 0; south_total = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: reset settings first
        send_cell(0, 0, 0, 0, 0, 0);                          // all equal
        send_cell(0, 65536, -65536, -65536, -65536, -65536);  // all neighbors lower
        send_cell(0, 65536, MX, MX, MX, MX);                  // all neighbors eliminated
        send_cell(MX, MX, MN, MN, MN, MN);                    // saturation
        send_cell(MN, MN, MX, MX, MX, MX);                    // centre deep below
        send_cell(MX, MN, MN, MX, MN, MX);
        send_cell(MN, MX, MN, MN, MN, MN);
        send_cell(100 * 65536, 65536, 99 * 65536, 101 * 65536, 100 * 65536, 98 * 65536);
        send_cell(0, 0, 66, -66, 0, 33);                      // epsilon ties
        send_cell(0, 5 * 65536, 65536, 2 * 65536, 3 * 65536, 4 * 65536); // multi-pass
        send_cell(-1, -1, -1, -1, -1, -1);
        drain();
        write_reg(REG_RATE, 17'd65536);
        write_reg(REG_EPS, 17'h0FFFF);
        send_cell(MX, MX, MN, MN, MN, MN);
        send_cell(0, 0, 0, 0, 0, 0);
        send_cell(0, 10 * 65536, 65536, 2 * 65536, 3 * 65536, 4 * 65536);
        send_cell(MN, 0, MN, MN, MN, MN);
        drain();
        write_reg(REG_RATE, 17'd0);
        write_reg(REG_EPS, 17'd0);
        send_cell(0, 65536, -65536, -65536, -65536, -65536);
        send_cell(0, 0, 0, 0, 0, 0);
        send_cell(MX, MX, MN, MN, MN, MN);
        drain();

        rates = '{17'd65536, 17'd1, 17'd0, 17'h1FFFF};
        epss  = '{16'd0, 16'hFFFF, 16'd66, 16'd1};
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(REG_RATE, ph < 4 ? rates[ph] : RATE_W'($urandom()));
            write_reg(REG_EPS, ph < 4 ? RATE_W'(epss[ph]) : RATE_W'(EPS_W'($urandom())));
            for (int i = 0; i < 240; i++)
                random_cell();
            drain();
        end

        if (errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
